### rtl/bc_pkg.sv
// Shared constants, command and status types for the binomial coefficient core.
// Depends on nothing; imported by bc_ctrl, bc_datapath and binomial_coefficient_core.
package bc_pkg;

    localparam int TOTAL_W      = 7;
    localparam int COEF_W       = 64;
    localparam int MAX_TOTAL    = 127;
    localparam int RESULT_WIDTH = 64;

    // product of the running value and a numerator factor
    localparam int PROD_W     = RESULT_WIDTH + TOTAL_W;
    // quotient bits resolved by the divider in one cycle
    localparam int DIV_RADIX  = 8;
    localparam int DIV_BITS   = ((PROD_W + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
    localparam int DIV_CYCLES = DIV_BITS / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [COEF_W-1:0] RESULT_LIMIT = COEF_W'({RESULT_WIDTH{1'b1}});

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic commit;
        logic publish;
    } bc_cmd_t;

    typedef struct packed {
        logic special;
        logic k_zero;
        logic last_step;
        logic div_last;
        logic q_ovf;
    } bc_status_t;

endpackage

### rtl/bc_ctrl.sv
// Sequencer for the binomial coefficient core: request handshakes and step control.
// Depends on bc_pkg; drives bc_datapath through bc_cmd_t and reads bc_status_t.
module bc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bc_pkg::bc_cmd_t   cmd,
    input  bc_pkg::bc_status_t st
);
    import bc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETUP  = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_COMMIT = 6'b010000,
        ST_DONE   = 6'b100000
    } bc_state_t;

    bc_state_t state_reg, state_next;
    logic      m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                if (st.special || st.k_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (st.q_ovf || st.last_step) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/bc_datapath.sv
// Datapath of the binomial coefficient core: operand registers, multiplier,
// radix-256 exact divider and output register. Depends on bc_pkg.
module bc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bc_pkg::TOTAL_W-1:0]    s_total,
    input  logic [bc_pkg::TOTAL_W-1:0]    s_chosen,
    input  bc_pkg::bc_cmd_t               cmd,
    output bc_pkg::bc_status_t            st,
    output logic [bc_pkg::COEF_W-1:0]     m_coefficient,
    output logic                          m_overflow
);
    import bc_pkg::*;

    logic [TOTAL_W-1:0]      n_reg, m_reg, k_reg, i_reg;
    logic [RESULT_WIDTH-1:0] r_reg;
    logic                    ovf_reg;
    logic [DIV_BITS-1:0]     div_reg, div_next;
    logic [TOTAL_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [COEF_W-1:0]       coef_reg;
    logic                    out_ovf_reg;

    logic [TOTAL_W-1:0]      diff, k_calc, num;
    logic                    reject, m_gt_n;
    logic [PROD_W-1:0]       prod;

    assign diff   = n_reg - m_reg;
    assign k_calc = (m_reg < diff) ? m_reg : diff;
    assign reject = {1'b0, n_reg} > 8'(MAX_TOTAL);
    assign m_gt_n = m_reg > n_reg;
    // numerator factor n - k + i, never above n
    assign num    = n_reg - k_reg + i_reg;
    assign prod   = PROD_W'(r_reg) * PROD_W'(num);

    assign st.special   = reject || m_gt_n;
    assign st.k_zero    = (k_calc == '0);
    assign st.last_step = (i_reg == k_reg);
    assign st.div_last  = (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));
    assign st.q_ovf     = (div_reg[DIV_BITS-1:RESULT_WIDTH] != '0);

    // DIV_RADIX restoring steps per cycle; remainder stays below i
    always_comb begin
        logic [TOTAL_W:0] trial;
        rem_next = rem_reg;
        div_next = div_reg;
        for (int b = 0; b < DIV_RADIX; b++) begin
            trial    = {rem_next, div_next[DIV_BITS-1]};
            div_next = {div_next[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, i_reg}) begin
                trial       = trial - {1'b0, i_reg};
                div_next[0] = 1'b1;
            end
            rem_next = trial[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= s_total;
            m_reg <= s_chosen;
        end
        if (cmd.setup) begin
            k_reg   <= k_calc;
            i_reg   <= TOTAL_W'(1);
            r_reg   <= m_gt_n ? '0 : RESULT_WIDTH'(1);
            ovf_reg <= reject;
        end
        if (cmd.mul) begin
            div_reg <= DIV_BITS'(prod);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            div_reg <= div_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit) begin
            if (st.q_ovf) begin
                ovf_reg <= 1'b1;
            end else begin
                r_reg <= div_reg[RESULT_WIDTH-1:0];
                i_reg <= i_reg + 1'b1;
            end
        end
        if (cmd.publish) begin
            coef_reg    <= ovf_reg ? RESULT_LIMIT : COEF_W'(r_reg);
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_coefficient = coef_reg;
    assign m_overflow    = out_ovf_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> i_reg != '0)
        else $error("divider running with a zero divisor");

    a_value_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && !st.q_ovf |=> r_reg >= $past(r_reg))
        else $error("partial coefficient shrank");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish && ovf_reg |=> coef_reg == RESULT_LIMIT && out_ovf_reg)
        else $error("overflowed result not saturated");
`endif

endmodule

### rtl/binomial_coefficient_core.sv
// Top level of the binomial coefficient core C(total, chosen).
// Depends on bc_pkg, bc_ctrl and bc_datapath.
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  request  | s_valid s_ready s_total s_chosen       | in
//  result   | m_valid m_ready m_coefficient m_overflow | out
//
// One request at a time. With k = min(chosen, total - chosen) the result is
// registered after k steps, or fewer if the value overflows: each step is one
// multiply, the divider steps (8 quotient bits a cycle) and one commit.
// Chosen above total, or k of zero, goes straight from setup to the result.
// A new request is taken as soon as the previous result sits in the output
// register; a stalled result holds the sequencer in its final state.
// Reset (aresetn, synchronous, active low) clears the sequencer and m_valid.
module binomial_coefficient_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [bc_pkg::TOTAL_W-1:0] s_total,
    input  logic [bc_pkg::TOTAL_W-1:0] s_chosen,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bc_pkg::COEF_W-1:0]  m_coefficient,
    output logic                       m_overflow
);
    import bc_pkg::*;

    bc_cmd_t    cmd;
    bc_status_t st;

    bc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

    bc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_total       (s_total),
        .s_chosen      (s_chosen),
        .cmd           (cmd),
        .st            (st),
        .m_coefficient (m_coefficient),
        .m_overflow    (m_overflow)
    );

endmodule
